>>> rtl/mrg_pkg.sv
// Shared types, constants and modular helpers for the MRG ellipse hit sampler.
package mrg_pkg;

	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int COUNT_WIDTH_DEF    = 32;

	localparam logic [31:0] MOD1 = 32'd4294967087;
	localparam logic [31:0] MOD2 = 32'd4294944443;

	// 2^32 mod m for each modulus
	localparam logic [14:0] FOLD1 = 15'd209;
	localparam logic [14:0] FOLD2 = 15'd22853;

	// recurrence multipliers; the negative taps are applied as m - (k*h mod m)
	localparam logic [20:0] MUL12 = 21'd1403580;
	localparam logic [20:0] NEG13 = 21'd810728;
	localparam logic [20:0] MUL21 = 21'd527612;
	localparam logic [20:0] NEG23 = 21'd1370589;

	localparam int NUM_COMP = 4;
	localparam int HIST_DEPTH = 3;
	localparam int SUM_W = 97;

	localparam logic [63:0] LIM = 64'(MOD1 - 32'd1) * 64'(MOD1 - 32'd1);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	localparam logic [0:0] REG_COEF_A = 1'b0;
	localparam logic [0:0] REG_COEF_B = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [3:0]  seed_index;
		logic [31:0] seed_value;
	} item_t;

	typedef struct packed {
		logic [31:0] x_value;
		logic [31:0] y_value;
		logic        hit;
		logic [31:0] hit_total;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_MUL,
		S_FOLD1,
		S_FOLD2,
		S_NEG,
		S_COMB,
		S_SQ,
		S_PP,
		S_TERM,
		S_SUM,
		S_CMP
	} state_t;

	typedef struct packed {
		logic take;
		logic load;
		logic mul;
		logic fold1;
		logic fold2;
		logic neg;
		logic comb;
		logic sq;
		logic pp;
		logic term;
		logic sum;
		logic cmp;
	} cmd_t;

	typedef struct packed {
		logic phase_done;
	} stat_t;

	function automatic logic [31:0] mod_of(input int k);
		return (k % 2 == 1) ? MOD2 : MOD1;
	endfunction

	function automatic logic [14:0] fold_of(input int k);
		return (k % 2 == 1) ? FOLD2 : FOLD1;
	endfunction

	// (a + b) mod m for a, b below m
	function automatic logic [31:0] mod_add(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] m);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, m}) ? 32'(s - {1'b0, m}) : s[31:0];
	endfunction

	// finish the reduction of a once-folded value
	function automatic logic [31:0] fold_tail(input logic [36:0] t, input logic [14:0] c,
			input logic [31:0] m);
		logic [32:0] u;
		u = 33'({28'b0, t[36:32]} * {18'b0, c}) + {1'b0, t[31:0]};
		return (u >= {1'b0, m}) ? 32'(u - {1'b0, m}) : u[31:0];
	endfunction

endpackage

>>> rtl/mrg32k3a_ellipse_hit_sampler.sv
// Top level of the MRG32k3a ellipse hit sampler.
// Two combined multiple recursive generators (two order-3 components each, moduli
// 2^32-209 and 2^32-22853) produce x and y; each coordinate is (c1 + c2) mod m1.
// A draw reports the point, whether coef_a*x^2 + coef_b*y^2 <= (m1-1)^2 with the
// coefficients in unsigned fixed point of COEF_FRAC_BITS fraction bits, and the
// saturating hit count since the last seed load. A load transfers one seed word
// into history slot seed_index (12-15 write nothing), clears the draw phase and
// the hit count, and gives no result. The block works on one item at a time under
// a sequencer: a load has one load step; the three draws after a load start at
// combine, a recurrence draw runs multiply, two modular folds and negative taps
// first; squaring, two partial-product stages, sum and compare follow. The output
// register holds a finished result while the next item is taken in; a draw
// waits at its last step only while an earlier result is still stalled.
// Configuration writes land at once on cfg_we and are meant for idle periods.
module mrg32k3a_ellipse_hit_sampler #(
	parameter int COEF_FRAC_BITS = mrg_pkg::COEF_FRAC_BITS_DEF,
	parameter int COUNT_WIDTH    = mrg_pkg::COUNT_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  mrg_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output mrg_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	mrg_pkg::cmd_t  cmd;
	mrg_pkg::stat_t stat;

	mrg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_kind    (item.kind),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	mrg_dp #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.COUNT_WIDTH    (COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

>>> rtl/mrg_ctrl.sv
// Sequencer that steps the sampler datapath through a load or a draw.
module mrg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic           item_kind,
	output logic           item_stall,
	output logic           result_valid,
	input  logic           result_stall,
	input  mrg_pkg::stat_t stat,
	output mrg_pkg::cmd_t  cmd
);

	mrg_pkg::state_t state_q, state_d;
	logic            take;
	logic            cmp_go;
	logic            result_valid_q;

	assign take   = (state_q == mrg_pkg::S_IDLE) && item_valid;
	assign cmp_go = (state_q == mrg_pkg::S_CMP) && (!result_valid_q || !result_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrg_pkg::S_IDLE: begin
				if (take) begin
					if (item_kind == mrg_pkg::KIND_LOAD)
						state_d = mrg_pkg::S_LOAD;
					else if (stat.phase_done)
						state_d = mrg_pkg::S_MUL;
					else
						state_d = mrg_pkg::S_COMB;
				end
			end
			mrg_pkg::S_LOAD:  state_d = mrg_pkg::S_IDLE;
			mrg_pkg::S_MUL:   state_d = mrg_pkg::S_FOLD1;
			mrg_pkg::S_FOLD1: state_d = mrg_pkg::S_FOLD2;
			mrg_pkg::S_FOLD2: state_d = mrg_pkg::S_NEG;
			mrg_pkg::S_NEG:   state_d = mrg_pkg::S_COMB;
			mrg_pkg::S_COMB:  state_d = mrg_pkg::S_SQ;
			mrg_pkg::S_SQ:    state_d = mrg_pkg::S_PP;
			mrg_pkg::S_PP:    state_d = mrg_pkg::S_TERM;
			mrg_pkg::S_TERM:  state_d = mrg_pkg::S_SUM;
			mrg_pkg::S_SUM:   state_d = mrg_pkg::S_CMP;
			mrg_pkg::S_CMP: begin
				if (cmp_go)
					state_d = mrg_pkg::S_IDLE;
			end
			default: state_d = mrg_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.take  = take;
		cmd.load  = (state_q == mrg_pkg::S_LOAD);
		cmd.mul   = (state_q == mrg_pkg::S_MUL);
		cmd.fold1 = (state_q == mrg_pkg::S_FOLD1);
		cmd.fold2 = (state_q == mrg_pkg::S_FOLD2);
		cmd.neg   = (state_q == mrg_pkg::S_NEG);
		cmd.comb  = (state_q == mrg_pkg::S_COMB);
		cmd.sq    = (state_q == mrg_pkg::S_SQ);
		cmd.pp    = (state_q == mrg_pkg::S_PP);
		cmd.term  = (state_q == mrg_pkg::S_TERM);
		cmd.sum   = (state_q == mrg_pkg::S_SUM);
		cmd.cmp   = cmp_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= mrg_pkg::S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmp_go)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	assign item_stall   = (state_q != mrg_pkg::S_IDLE);
	assign result_valid = result_valid_q;

endmodule

>>> rtl/mrg_dp.sv
// Datapath: generator histories, modular recurrence, ellipse test and hit count.
module mrg_dp #(
	parameter int COEF_FRAC_BITS = mrg_pkg::COEF_FRAC_BITS_DEF,
	parameter int COUNT_WIDTH    = mrg_pkg::COUNT_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mrg_pkg::item_t   item,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  mrg_pkg::cmd_t    cmd,
	output mrg_pkg::stat_t   stat,
	output mrg_pkg::result_t result
);

	localparam logic [mrg_pkg::SUM_W-1:0] BOUND =
		mrg_pkg::SUM_W'(mrg_pkg::LIM) << COEF_FRAC_BITS;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	mrg_pkg::item_t   item_q;
	logic [31:0]      hist_q [mrg_pkg::NUM_COMP][mrg_pkg::HIST_DEPTH];
	logic [1:0]       phase_q;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_next;
	logic [31:0]      coef_a_q, coef_b_q;

	logic [52:0]      prod_a_s1 [mrg_pkg::NUM_COMP];
	logic [52:0]      prod_b_s1 [mrg_pkg::NUM_COMP];
	logic [36:0]      fold_a_s2 [mrg_pkg::NUM_COMP];
	logic [36:0]      fold_b_s2 [mrg_pkg::NUM_COMP];
	logic [31:0]      rem_a_s3  [mrg_pkg::NUM_COMP];
	logic [31:0]      rem_b_s3  [mrg_pkg::NUM_COMP];
	logic [31:0]      xv_s4, yv_s4;
	logic [63:0]      xx_s5, yy_s5;
	logic [63:0]      pa_lo_s6, pa_hi_s6, pb_lo_s6, pb_hi_s6;
	logic [95:0]      ta_s7, tb_s7;
	logic [mrg_pkg::SUM_W-1:0] sum_s8;
	mrg_pkg::result_t result_q;

	logic             seed_ok;
	logic [1:0]       seed_comp;
	logic [1:0]       seed_pos;
	logic [31:0]      seed_mod;
	logic [31:0]      seed_red;
	logic [1:0]       sel;
	logic             hit;

	// seed index to component and position
	always_comb begin
		seed_ok   = 1'b1;
		seed_comp = 2'd0;
		seed_pos  = 2'd0;
		unique case (item_q.seed_index) inside
			[4'd0:4'd2]: begin
				seed_comp = 2'd0;
				seed_pos  = 2'(item_q.seed_index);
			end
			[4'd3:4'd5]: begin
				seed_comp = 2'd1;
				seed_pos  = 2'(item_q.seed_index - 4'd3);
			end
			[4'd6:4'd8]: begin
				seed_comp = 2'd2;
				seed_pos  = 2'(item_q.seed_index - 4'd6);
			end
			[4'd9:4'd11]: begin
				seed_comp = 2'd3;
				seed_pos  = 2'(item_q.seed_index - 4'd9);
			end
			default: seed_ok = 1'b0;
		endcase
	end

	assign seed_mod = seed_comp[0] ? mrg_pkg::MOD2 : mrg_pkg::MOD1;
	assign seed_red = (item_q.seed_value >= seed_mod) ?
		item_q.seed_value - seed_mod : item_q.seed_value;

	// first three draws after a load read the seed words, then the newest word
	assign sel      = (phase_q == 2'd3) ? 2'd2 : phase_q;
	assign hit      = (sum_s8 <= BOUND);
	assign cnt_next = (hit && cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < mrg_pkg::NUM_COMP; k++)
				for (int j = 0; j < mrg_pkg::HIST_DEPTH; j++)
					hist_q[k][j] <= '0;
			phase_q  <= '0;
			cnt_q    <= '0;
			coef_a_q <= 32'd65536;
			coef_b_q <= 32'd65536;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					mrg_pkg::REG_COEF_A: coef_a_q <= cfg_data;
					mrg_pkg::REG_COEF_B: coef_b_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				if (seed_ok)
					hist_q[seed_comp][seed_pos] <= seed_red;
				phase_q <= '0;
				cnt_q   <= '0;
			end
			if (cmd.neg) begin
				// shift in the new word as the newest
				for (int k = 0; k < mrg_pkg::NUM_COMP; k++) begin
					hist_q[k][0] <= hist_q[k][1];
					hist_q[k][1] <= hist_q[k][2];
					hist_q[k][2] <= mrg_pkg::mod_add(rem_a_s3[k],
						(rem_b_s3[k] == 32'd0) ? 32'd0 : mrg_pkg::mod_of(k) - rem_b_s3[k],
						mrg_pkg::mod_of(k));
				end
			end
			if (cmd.comb && phase_q != 2'd3)
				phase_q <= phase_q + 2'd1;
			if (cmd.cmp)
				cnt_q <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take)
			item_q <= item;
		if (cmd.mul) begin
			for (int k = 0; k < mrg_pkg::NUM_COMP; k++) begin
				if (k % 2 == 1) begin
					prod_a_s1[k] <= {21'b0, hist_q[k][2]} * {32'b0, mrg_pkg::MUL21};
					prod_b_s1[k] <= {21'b0, hist_q[k][0]} * {32'b0, mrg_pkg::NEG23};
				end else begin
					prod_a_s1[k] <= {21'b0, hist_q[k][1]} * {32'b0, mrg_pkg::MUL12};
					prod_b_s1[k] <= {21'b0, hist_q[k][0]} * {32'b0, mrg_pkg::NEG13};
				end
			end
		end
		if (cmd.fold1) begin
			// fold the high part down with 2^32 = c (mod m)
			for (int k = 0; k < mrg_pkg::NUM_COMP; k++) begin
				fold_a_s2[k] <= {16'b0, prod_a_s1[k][52:32]} * {22'b0, mrg_pkg::fold_of(k)}
					+ {5'b0, prod_a_s1[k][31:0]};
				fold_b_s2[k] <= {16'b0, prod_b_s1[k][52:32]} * {22'b0, mrg_pkg::fold_of(k)}
					+ {5'b0, prod_b_s1[k][31:0]};
			end
		end
		if (cmd.fold2) begin
			for (int k = 0; k < mrg_pkg::NUM_COMP; k++) begin
				rem_a_s3[k] <= mrg_pkg::fold_tail(fold_a_s2[k], mrg_pkg::fold_of(k),
					mrg_pkg::mod_of(k));
				rem_b_s3[k] <= mrg_pkg::fold_tail(fold_b_s2[k], mrg_pkg::fold_of(k),
					mrg_pkg::mod_of(k));
			end
		end
		if (cmd.comb) begin
			xv_s4 <= mrg_pkg::mod_add(hist_q[0][sel], hist_q[1][sel], mrg_pkg::MOD1);
			yv_s4 <= mrg_pkg::mod_add(hist_q[2][sel], hist_q[3][sel], mrg_pkg::MOD1);
		end
		if (cmd.sq) begin
			xx_s5 <= {32'b0, xv_s4} * {32'b0, xv_s4};
			yy_s5 <= {32'b0, yv_s4} * {32'b0, yv_s4};
		end
		if (cmd.pp) begin
			pa_lo_s6 <= {32'b0, coef_a_q} * {32'b0, xx_s5[31:0]};
			pa_hi_s6 <= {32'b0, coef_a_q} * {32'b0, xx_s5[63:32]};
			pb_lo_s6 <= {32'b0, coef_b_q} * {32'b0, yy_s5[31:0]};
			pb_hi_s6 <= {32'b0, coef_b_q} * {32'b0, yy_s5[63:32]};
		end
		if (cmd.term) begin
			ta_s7 <= {32'b0, pa_lo_s6} + {pa_hi_s6, 32'b0};
			tb_s7 <= {32'b0, pb_lo_s6} + {pb_hi_s6, 32'b0};
		end
		if (cmd.sum)
			sum_s8 <= {1'b0, ta_s7} + {1'b0, tb_s7};
		if (cmd.cmp) begin
			result_q.x_value   <= xv_s4;
			result_q.y_value   <= yv_s4;
			result_q.hit       <= hit;
			result_q.hit_total <= 32'(cnt_next);
		end
	end

	assign stat.phase_done = (phase_q == 2'd3);
	assign result          = result_q;

endmodule

>>> rtl/mrg_chk.sv
// Port-level checks for the sampler, bound to the top level.
module mrg_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input mrg_pkg::result_t result
);

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	// coordinates are reduced mod m1
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.x_value < mrg_pkg::MOD1) && (result.y_value < mrg_pkg::MOD1))
		else $error("coordinate out of range");

	// a new result only follows a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result without a draw in progress");

endmodule

bind mrg32k3a_ellipse_hit_sampler mrg_chk u_chk (.*);
